@@ hw/rtl/rgbc_pkg.sv @@
`default_nettype none

package rgbc_pkg;

    // channel widths
    localparam int CH_W   = 16;
    localparam int NORM_W = 8;

    localparam logic [CH_W-1:0]   U16_MAX   = 16'hFFFF;
    localparam logic [NORM_W-1:0] NORM_FULL = 8'd255;

    // DN40 color temperature: slope * blue' / red' + offset
    localparam logic [11:0]     CCT_SLOPE  = 12'd3810;
    localparam logic [CH_W-1:0] CCT_OFFSET = 16'd1391;

    // lux weights (x10000), red and blue weights are negative
    localparam logic [11:0] LUX_WR_MAG = 12'd3247;
    localparam logic [13:0] LUX_WG     = 14'd15784;
    localparam logic [12:0] LUX_WB_MAG = 13'd7319;
    localparam int          LUX_SCALE  = 10000;

    // weighted sum at or above this saturates the lux output
    localparam logic [29:0] LUX_SAT_LIM = 30'(65536 * LUX_SCALE);

    // divide by 10000 = shift by 4, then exact reciprocal multiply for /625
    localparam int          LUX_PRE_SHIFT   = 4;
    localparam int          LUX_Y_W         = 26;
    localparam logic [26:0] LUX_RECIP       = 27'd109951163;
    localparam int          LUX_RECIP_SHIFT = 36;
    localparam int          LUX_PROD_W      = LUX_Y_W + 27;

    // divider geometry
    localparam int CCT_QW     = 16;
    localparam int CCT_NUM_W  = 28;
    localparam int NORM_QW    = 8;
    localparam int NORM_NUM_W = CH_W + NORM_QW;
    localparam int NORM_DLY   = CCT_QW - NORM_QW;

    // one classified reading, front to back
    typedef struct packed {
        logic               c_zero;
        logic               cct_zero;
        logic               r_sat;
        logic               g_sat;
        logic               b_sat;
        logic               lux_pos;
        logic               lux_sat;
        logic [CH_W-1:0]    rc;
        logic [CH_W-1:0]    bc;
        logic [LUX_Y_W-1:0] lux_y;
        logic [CH_W-1:0]    clear;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
    } rgbc_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rgbc_fifo_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/rgbc_if.sv @@
`default_nettype none

// sensor reading channel
interface rgbc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] clear_count;
    logic [15:0] red_count;
    logic [15:0] green_count;
    logic [15:0] blue_count;

    modport source (output valid, output clear_count, output red_count,
                    output green_count, output blue_count, input ready);
    modport sink   (input valid, input clear_count, input red_count,
                    input green_count, input blue_count, output ready);
endinterface

// metrics result channel
interface rgbc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] color_temp_kelvin;
    logic [15:0] lux_value;
    logic [7:0]  red_norm;
    logic [7:0]  green_norm;
    logic [7:0]  blue_norm;

    modport source (output valid, output color_temp_kelvin, output lux_value,
                    output red_norm, output green_norm, output blue_norm,
                    input ready);
    modport sink   (input valid, input color_temp_kelvin, input lux_value,
                    input red_norm, input green_norm, input blue_norm,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rgbc_color_metrics_core.sv @@
`default_nettype none

// Channel   Dir  Beat fields
// -------   ---  ------------------------------------------------------
// sample    in   clear_count, red_count, green_count, blue_count (16b)
// result    out  color_temp_kelvin, lux_value (16b), red/green/blue_norm (8b)
//
// One reading per cycle sustained while result beats are taken; each
// sample passes two front stages, the queue, one multiply stage, the
// 16-stage color temperature divider and the output register. Reset
// (rst_n low, async) empties every stage and the queue. A stalled result
// holds the back pipeline; the front keeps taking beats until the
// FIFO_DEPTH-entry queue fills.
module rgbc_color_metrics_core
    import rgbc_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rgbc_in_if.sink    sample,
    rgbc_out_if.source result
);

    logic            push;
    logic            pop;
    rgbc_job_t       wdata;
    rgbc_job_t       rdata;
    rgbc_fifo_stat_t stat;

    rgbc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .stat   (stat),
        .push   (push),
        .job    (wdata)
    );

    rgbc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wdata),
        .pop   (pop),
        .rdata (rdata),
        .stat  (stat)
    );

    rgbc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .stat   (stat),
        .job    (rdata),
        .pop    (pop),
        .result (result)
    );

    // back side never drains the queue while a result beat is held
    a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !pop)
        else $error("queue popped while result stalled");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("pop from empty queue");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("push into full queue");

    // the front only refuses beats because the queue is full
    a_front_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> stat.full)
        else $error("sample not ready with room in queue");

endmodule

`default_nettype wire

@@ hw/rtl/rgbc_front.sv @@
`default_nettype none

module rgbc_front
    import rgbc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    rgbc_in_if.sink        sample,
    input  rgbc_fifo_stat_t stat,
    output logic           push,
    output rgbc_job_t      job
);

    typedef struct packed {
        logic [CH_W-1:0] clear;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [17:0]     sum;
        logic [27:0]     pr;
        logic [29:0]     pg;
        logic [28:0]     pb;
    } f1_t;

    logic      adv;
    logic      f1_vld_reg;
    logic      f2_vld_reg;
    f1_t       f1_reg;
    f1_t       f1_next;
    rgbc_job_t f2_reg;
    rgbc_job_t f2_next;

    logic [17:0] excess;
    logic [16:0] ir;
    logic        r_ok;
    logic        b_ok;
    logic [29:0] neg_sum;
    logic [29:0] lux_diff;

    // both stages move together unless stage 2 holds a reading and the queue is full
    assign adv          = !f2_vld_reg || !stat.full;
    assign sample.ready = adv;
    assign push         = f2_vld_reg && !stat.full;
    assign job          = f2_reg;

    // stage 1: channel sum and lux partial products
    always_comb
    begin
        f1_next.clear = sample.clear_count;
        f1_next.red   = sample.red_count;
        f1_next.green = sample.green_count;
        f1_next.blue  = sample.blue_count;
        f1_next.sum   = 18'(sample.red_count) + 18'(sample.green_count)
                      + 18'(sample.blue_count);
        f1_next.pr    = 28'(sample.red_count) * 28'(LUX_WR_MAG);
        f1_next.pg    = 30'(sample.green_count) * 30'(LUX_WG);
        f1_next.pb    = 29'(sample.blue_count) * 29'(LUX_WB_MAG);
    end

    // stage 2: IR estimate, corrected channels and special-case flags
    always_comb
    begin
        excess   = f1_reg.sum - 18'(f1_reg.clear);
        ir       = (f1_reg.sum > 18'(f1_reg.clear)) ? excess[17:1] : '0;
        r_ok     = 17'(f1_reg.red) > ir;
        b_ok     = 17'(f1_reg.blue) > ir;
        neg_sum  = 30'(f1_reg.pr) + 30'(f1_reg.pb);
        lux_diff = f1_reg.pg - neg_sum;

        f2_next.c_zero   = (f1_reg.clear == '0);
        f2_next.cct_zero = (f1_reg.clear == '0) || (f1_reg.clear == U16_MAX)
                         || !r_ok || !b_ok;
        f2_next.r_sat    = f1_reg.red >= f1_reg.clear;
        f2_next.g_sat    = f1_reg.green >= f1_reg.clear;
        f2_next.b_sat    = f1_reg.blue >= f1_reg.clear;
        f2_next.lux_pos  = f1_reg.pg > neg_sum;
        f2_next.lux_sat  = lux_diff >= LUX_SAT_LIM;
        f2_next.rc       = f1_reg.red - ir[CH_W-1:0];
        f2_next.bc       = f1_reg.blue - ir[CH_W-1:0];
        f2_next.lux_y    = lux_diff[LUX_PRE_SHIFT +: LUX_Y_W];
        f2_next.clear    = f1_reg.clear;
        f2_next.red      = f1_reg.red;
        f2_next.green    = f1_reg.green;
        f2_next.blue     = f1_reg.blue;
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_vld_reg <= sample.valid;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rgbc_fifo.sv @@
`default_nettype none

module rgbc_fifo
    import rgbc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  rgbc_job_t       wdata,
    input  wire logic       pop,
    output rgbc_job_t       rdata,
    output rgbc_fifo_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rgbc_job_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rgbc_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per stage. The dividend must be
// below den << Q_W; otherwise the quotient is meaningless.
module rgbc_div
#(
    parameter int DEN_W = 16,
    parameter int Q_W   = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic [DEN_W+Q_W-1:0]   num,
    input  wire logic [DEN_W-1:0]       den,
    output logic      [Q_W-1:0]         quo
);

    localparam int CW = DEN_W + Q_W;

    logic [CW-1:0]    rem_reg [Q_W-1];
    logic [DEN_W-1:0] den_reg [Q_W-1];
    logic [Q_W-1:0]   quo_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        logic [CW-1:0]    rem_in;
        logic [CW-1:0]    den_sh;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   quo_in;
        logic [Q_W-1:0]   quo_out;
        logic             fits;

        if (i == 0)
        begin : g_head
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_tail
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        // trial subtract of the divisor aligned to this quotient bit
        assign den_sh = CW'(den_in) << (Q_W - 1 - i);
        assign fits   = rem_in >= den_sh;

        always_comb
        begin
            quo_out = quo_in;
            quo_out[Q_W-1-i] = fits;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[i] <= quo_out;
            end
        end

        if (i < Q_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= fits ? rem_in - den_sh : rem_in;
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/rgbc_back.sv @@
`default_nettype none

module rgbc_back
    import rgbc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  rgbc_fifo_stat_t stat,
    input  rgbc_job_t       job,
    output logic            pop,
    rgbc_out_if.source      result
);

    localparam int BACK_LAT = 1 + CCT_QW;

    typedef struct packed {
        logic            cct_zero;
        logic            cct_ovf;
        logic            c_zero;
        logic            r_sat;
        logic            g_sat;
        logic            b_sat;
        logic [CH_W-1:0] lux;
    } side_t;

    typedef struct packed {
        logic [NORM_W-1:0] r;
        logic [NORM_W-1:0] g;
        logic [NORM_W-1:0] b;
    } nq_t;

    typedef struct packed {
        logic [CH_W-1:0]   cct;
        logic [CH_W-1:0]   lux;
        logic [NORM_W-1:0] r;
        logic [NORM_W-1:0] g;
        logic [NORM_W-1:0] b;
    } res_t;

    logic adv;

    logic                  vld_reg [BACK_LAT];
    rgbc_job_t             s0_job_reg;
    logic [CCT_NUM_W-1:0]  s0_cct_num_reg;
    logic [LUX_PROD_W-1:0] s0_lux_prod_reg;
    logic [NORM_NUM_W-1:0] s0_rn_reg;
    logic [NORM_NUM_W-1:0] s0_gn_reg;
    logic [NORM_NUM_W-1:0] s0_bn_reg;

    side_t side_next;
    side_t side_dly_reg [CCT_QW];
    nq_t   nq_now;
    nq_t   nq_dly_reg [NORM_DLY];

    logic [CCT_QW-1:0] cct_q;
    logic [CH_W:0]     cct_sum;
    side_t             side_out;
    nq_t               nq_out;

    logic out_vld_reg;
    res_t out_reg;
    res_t out_next;

    // whole back pipeline holds while a result beat waits
    assign adv = !out_vld_reg || result.ready;
    assign pop = adv && !stat.empty;

    // stage 0 payload: constant multiplies on the queue head
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_job_reg      <= job;
            s0_cct_num_reg  <= CCT_NUM_W'(job.bc) * CCT_NUM_W'(CCT_SLOPE);
            s0_lux_prod_reg <= LUX_PROD_W'(job.lux_y) * LUX_PROD_W'(LUX_RECIP);
            s0_rn_reg       <= NORM_NUM_W'(job.red) * NORM_NUM_W'(NORM_FULL);
            s0_gn_reg       <= NORM_NUM_W'(job.green) * NORM_NUM_W'(NORM_FULL);
            s0_bn_reg       <= NORM_NUM_W'(job.blue) * NORM_NUM_W'(NORM_FULL);
        end
    end

    // quotient overflow check and lux select, alongside the first divider bit
    always_comb
    begin
        side_next.cct_zero = s0_job_reg.cct_zero;
        side_next.cct_ovf  = (32'(s0_cct_num_reg)) >= {s0_job_reg.rc, {CCT_QW{1'b0}}};
        side_next.c_zero   = s0_job_reg.c_zero;
        side_next.r_sat    = s0_job_reg.r_sat;
        side_next.g_sat    = s0_job_reg.g_sat;
        side_next.b_sat    = s0_job_reg.b_sat;
        if (!s0_job_reg.lux_pos)
        begin
            side_next.lux = '0;
        end
        else if (s0_job_reg.lux_sat)
        begin
            side_next.lux = U16_MAX;
        end
        else
        begin
            side_next.lux = s0_lux_prod_reg[LUX_RECIP_SHIFT +: CH_W];
        end
    end

    rgbc_div #(.DEN_W(CH_W), .Q_W(CCT_QW)) u_cct_div (
        .clk (clk),
        .en  (adv),
        .num (32'(s0_cct_num_reg)),
        .den (s0_job_reg.rc),
        .quo (cct_q)
    );

    rgbc_div #(.DEN_W(CH_W), .Q_W(NORM_QW)) u_red_div (
        .clk (clk),
        .en  (adv),
        .num (s0_rn_reg),
        .den (s0_job_reg.clear),
        .quo (nq_now.r)
    );

    rgbc_div #(.DEN_W(CH_W), .Q_W(NORM_QW)) u_green_div (
        .clk (clk),
        .en  (adv),
        .num (s0_gn_reg),
        .den (s0_job_reg.clear),
        .quo (nq_now.g)
    );

    rgbc_div #(.DEN_W(CH_W), .Q_W(NORM_QW)) u_blue_div (
        .clk (clk),
        .en  (adv),
        .num (s0_bn_reg),
        .den (s0_job_reg.clear),
        .quo (nq_now.b)
    );

    // flags ride beside the color temperature divider, norms wait to align
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_dly_reg[0] <= side_next;
            for (int k = 1; k < CCT_QW; k++)
            begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
            nq_dly_reg[0] <= nq_now;
            for (int k = 1; k < NORM_DLY; k++)
            begin
                nq_dly_reg[k] <= nq_dly_reg[k-1];
            end
        end
    end

    assign side_out = side_dly_reg[CCT_QW-1];
    assign nq_out   = nq_dly_reg[NORM_DLY-1];

    // final offset, saturation and zero cases
    always_comb
    begin
        cct_sum = (CH_W+1)'(cct_q) + (CH_W+1)'(CCT_OFFSET);
        if (side_out.cct_zero)
        begin
            out_next.cct = '0;
        end
        else if (side_out.cct_ovf || cct_sum[CH_W])
        begin
            out_next.cct = U16_MAX;
        end
        else
        begin
            out_next.cct = cct_sum[CH_W-1:0];
        end
        out_next.lux = side_out.lux;
        out_next.r   = side_out.c_zero ? '0 : (side_out.r_sat ? NORM_FULL : nq_out.r);
        out_next.g   = side_out.c_zero ? '0 : (side_out.g_sat ? NORM_FULL : nq_out.g);
        out_next.b   = side_out.c_zero ? '0 : (side_out.b_sat ? NORM_FULL : nq_out.b);
    end

    // stage valids and result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BACK_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= !stat.empty;
            for (int k = 1; k < BACK_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_vld_reg <= vld_reg[BACK_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid             = out_vld_reg;
    assign result.color_temp_kelvin = out_reg.cct;
    assign result.lux_value         = out_reg.lux;
    assign result.red_norm          = out_reg.r;
    assign result.green_norm        = out_reg.g;
    assign result.blue_norm         = out_reg.b;

endmodule

`default_nettype wire

@@ test/tb_rgbc_color_metrics_core.sv @@
`timescale 1ns / 100ps

module tb_rgbc_color_metrics_core;

    // DN40 and lux constants, lux weights scaled by 10000
    localparam int unsigned CCT_K    = 3810;
    localparam int unsigned CCT_OFS  = 1391;
    localparam longint      LUX_W_R  = -3247;
    localparam longint      LUX_W_G  = 15784;
    localparam longint      LUX_W_B  = -7319;
    localparam longint      LUX_DIV  = 10000;
    localparam int unsigned NORM_TOP = 255;

    localparam int N_DIR          = 22;
    localparam int N_RANDOM       = 900;
    localparam int PRESSURE_BEATS = 40;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 40;
    localparam int IDLE_LIMIT     = 2000;

    typedef struct packed {
        logic [15:0] clear;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } reading_t;

    typedef struct packed {
        logic [15:0] cct;
        logic [15:0] lux;
        logic [7:0]  red_n;
        logic [7:0]  green_n;
        logic [7:0]  blue_n;
    } metrics_t;

    typedef struct packed {
        reading_t rd;
        logic     typed;
        metrics_t want;
    } reading_row_t;

    logic clk;
    logic rst_n;

    rgbc_in_if  sample_if();
    rgbc_out_if result_if();

    rgbc_color_metrics_core u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if)
    );

    // directed readings: extremes and edge cases, typed results where obvious
    reading_row_t dir_rows [N_DIR] = '{
        // all zero right after reset
        '{'{16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '{16'd0, 16'd0, 8'd0, 8'd0, 8'd0}},
        // clear zero, channels at full scale
        '{'{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
          '{16'd0, 16'd34196, 8'd0, 8'd0, 8'd0}},
        // everything saturated
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
          '{16'd0, 16'd34196, 8'd255, 8'd255, 8'd255}},
        '{'{16'hFFFF, 16'd0, 16'd0, 16'd0}, 1'b1, '{16'd0, 16'd0, 8'd0, 8'd0, 8'd0}},
        // green only: lux saturates
        '{'{16'hFFFF, 16'd0, 16'hFFFF, 16'd0}, 1'b1,
          '{16'd0, 16'hFFFF, 8'd0, 8'd255, 8'd0}},
        // smallest positive lux
        '{'{16'hFFFF, 16'd0, 16'd1, 16'd0}, 1'b1, '{16'd0, 16'd1, 8'd0, 8'd0, 8'd0}},
        // red only: negative lux, red above clear
        '{'{16'd100, 16'hFFFF, 16'd0, 16'd0}, 1'b1, '{16'd0, 16'd0, 8'd255, 8'd0, 8'd0}},
        // smallest clear, every channel equal to it
        '{'{16'd1, 16'd1, 16'd1, 16'd1}, 1'b1, '{16'd0, 16'd0, 8'd255, 8'd255, 8'd255}},
        // color temperature saturates
        '{'{16'd40000, 16'd100, 16'd0, 16'd30000}, 1'b1,
          '{16'hFFFF, 16'd0, 8'd0, 8'd0, 8'd191}},
        // clear zero with small positive lux sum below one unit
        '{'{16'd0, 16'd1, 16'd2, 16'd3}, 1'b1, '{16'd0, 16'd0, 8'd0, 8'd0, 8'd0}},
        // ordinary reading with some IR
        '{'{16'd1000, 16'd400, 16'd350, 16'd300}, 1'b0, '0},
        // corrected red not positive
        '{'{16'd100, 16'd10, 16'd200, 16'd50}, 1'b0, '0},
        // corrected red of one
        '{'{16'd100, 16'd81, 16'd79, 16'd100}, 1'b0, '0},
        // corrected blue of one
        '{'{16'd100, 16'd100, 16'd79, 16'd81}, 1'b0, '0},
        // corrected blue exactly zero
        '{'{16'd100, 16'd90, 16'd90, 16'd80}, 1'b0, '0},
        // clear just below saturation
        '{'{16'd65534, 16'd20000, 16'd25000, 16'd15000}, 1'b0, '0},
        '{'{16'd65534, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        // alternating bit patterns
        '{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '0},
        '{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '0},
        // IR equals red
        '{'{16'd1000, 16'd1000, 16'd1000, 16'd1000}, 1'b0, '0},
        // odd excess, IR rounds down to zero
        '{'{16'd1001, 16'd500, 16'd500, 16'd2}, 1'b0, '0},
        '{'{16'd8000, 16'd8000, 16'd0, 16'd8000}, 1'b0, '0}
    };

    metrics_t    pending_metrics [$];
    int          outstanding = 0;
    int          mismatch_cnt = 0;
    int          idle_cycles = 0;
    bit          hold_off_req = 1'b0;
    logic        staged_typed;
    metrics_t    staged_metrics;

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // channel value scaled to clear, 0..255
    function automatic logic [7:0] scale_to_clear(logic [15:0] ch, logic [15:0] c);
        int unsigned v;
        if (c == 16'd0)
            return 8'd0;
        v = (32'(ch) * NORM_TOP) / 32'(c);
        return (v > NORM_TOP) ? 8'd255 : v[7:0];
    endfunction

    // color temperature, lux and normalized channels of one reading
    function automatic metrics_t color_metrics_of(reading_t rd);
        metrics_t    m;
        int unsigned sum;
        int unsigned ir;
        int unsigned rc;
        int unsigned bc;
        int unsigned q;
        longint      acc;
        longint      lq;

        m = '0;
        // DN40: subtract the IR estimate, then slope * blue' / red' + offset
        if (rd.clear != 16'd0 && rd.clear != 16'hFFFF)
        begin
            sum = 32'(rd.red) + 32'(rd.green) + 32'(rd.blue);
            ir  = (sum > 32'(rd.clear)) ? (sum - 32'(rd.clear)) / 2 : 0;
            if (32'(rd.red) > ir && 32'(rd.blue) > ir)
            begin
                rc = 32'(rd.red) - ir;
                bc = 32'(rd.blue) - ir;
                q  = (CCT_K * bc) / rc + CCT_OFS;
                m.cct = (q > 32'd65535) ? 16'hFFFF : q[15:0];
            end
        end

        // lux: signed weighted sum, truncated, clamped
        acc = LUX_W_R * longint'(32'(rd.red)) + LUX_W_G * longint'(32'(rd.green))
            + LUX_W_B * longint'(32'(rd.blue));
        if (acc > 0)
        begin
            lq = acc / LUX_DIV;
            m.lux = (lq > 65535) ? 16'hFFFF : lq[15:0];
        end

        m.red_n   = scale_to_clear(rd.red, rd.clear);
        m.green_n = scale_to_clear(rd.green, rd.clear);
        m.blue_n  = scale_to_clear(rd.blue, rd.clear);
        return m;
    endfunction

    function automatic reading_t random_reading();
        int unsigned c;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        reading_t    rd;

        case ($urandom_range(0, 9))
            // plausible readings: channels share clear, moderate IR
            0, 1, 2, 3:
            begin
                c = $urandom_range(1, 65534);
                r = $urandom_range(0, c / 2);
                g = $urandom_range(0, c / 2);
                b = $urandom_range(0, c / 2);
            end
            4:
            begin
                c = $urandom;
                r = $urandom;
                g = $urandom;
                b = $urandom;
            end
            // small counts, clear zero now and then
            5:
            begin
                c = $urandom_range(0, 255);
                r = $urandom_range(0, 255);
                g = $urandom_range(0, 255);
                b = $urandom_range(0, 255);
            end
            // clear at or next to its limits
            6:
            begin
                case ($urandom_range(0, 3))
                    0: c = 0;
                    1: c = 1;
                    2: c = 65534;
                    default: c = 65535;
                endcase
                r = $urandom;
                g = $urandom;
                b = $urandom;
            end
            // strong blue over weak red: color temperature near or past saturation
            7:
            begin
                r = $urandom_range(1, 64);
                b = $urandom_range(1000, 60000);
                g = $urandom_range(0, 500);
                c = r + g + b + $urandom_range(0, 3000);
            end
            // green heavy: lux near or past its clamp
            8:
            begin
                g = $urandom_range(40000, 65535);
                r = $urandom_range(0, 3000);
                b = $urandom_range(0, 3000);
                c = $urandom;
            end
            // clear around R+G+B: corrected red/blue near zero
            default:
            begin
                r = $urandom_range(0, 2000);
                b = $urandom_range(0, 2000);
                g = $urandom_range(0, 4000);
                c = $urandom_range(1, r + g + b + 1);
            end
        endcase
        rd.clear = c[15:0];
        rd.red   = r[15:0];
        rd.green = g[15:0];
        rd.blue  = b[15:0];
        return rd;
    endfunction

    // offer one reading after the idle gap given by gap, return once it is taken
    task automatic send_reading(reading_t rd, logic typed, metrics_t want,
                                int unsigned gap);
        repeat (gap)
        begin
            @(negedge clk);
            sample_if.valid <= 1'b0;
        end
        @(negedge clk);
        sample_if.valid       <= 1'b1;
        sample_if.clear_count <= rd.clear;
        sample_if.red_count   <= rd.red;
        sample_if.green_count <= rd.green;
        sample_if.blue_count  <= rd.blue;
        staged_typed   = typed;
        staged_metrics = want;
        do
            @(posedge clk);
        while (!sample_if.ready);
    endtask

    // drop valid and wait for every pending result
    task automatic drain_results();
        @(negedge clk);
        sample_if.valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // scoreboard: check result beats, record sample beats, watchdog
    always @(posedge clk)
    begin
        metrics_t want;
        metrics_t got;
        logic     any_beat;

        if (rst_n)
        begin
            any_beat = 1'b0;
            if (result_if.valid && result_if.ready)
            begin
                any_beat = 1'b1;
                got.cct     = result_if.color_temp_kelvin;
                got.lux     = result_if.lux_value;
                got.red_n   = result_if.red_norm;
                got.green_n = result_if.green_norm;
                got.blue_n  = result_if.blue_norm;
                if (pending_metrics.size() == 0)
                begin
                    $error("result beat with no reading pending");
                    mismatch_cnt++;
                end
                else
                begin
                    want = pending_metrics.pop_front();
                    outstanding--;
                    check_field("color_temp_kelvin", want.cct, got.cct);
                    check_field("lux_value", want.lux, got.lux);
                    check_field("red_norm", 16'(want.red_n), 16'(got.red_n));
                    check_field("green_norm", 16'(want.green_n), 16'(got.green_n));
                    check_field("blue_norm", 16'(want.blue_n), 16'(got.blue_n));
                end
            end
            if (sample_if.valid && sample_if.ready)
            begin
                any_beat = 1'b1;
                if (staged_typed)
                    pending_metrics.push_back(staged_metrics);
                else
                    pending_metrics.push_back(color_metrics_of({sample_if.clear_count,
                        sample_if.red_count, sample_if.green_count, sample_if.blue_count}));
                outstanding++;
            end

            idle_cycles = any_beat ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side: random stalls, no-stall stretches, one long hold-off
    initial
    begin
        int unsigned stall;
        int unsigned beats;
        bit          held;

        beats = 0;
        held  = 1'b0;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req && !held)
            begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            else if (beats % 80 < 20)
                stall = 0;
            else
                stall = $urandom_range(0, 8);
            repeat (stall)
            begin
                @(negedge clk);
                result_if.ready <= 1'b0;
            end
            @(negedge clk);
            result_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_if.valid);
            beats++;
        end
    end

    // stimulus
    initial
    begin
        int unsigned gap;

        rst_n                 = 1'b0;
        sample_if.valid       = 1'b0;
        sample_if.clear_count = '0;
        sample_if.red_count   = '0;
        sample_if.green_count = '0;
        sample_if.blue_count  = '0;
        staged_typed          = 1'b0;
        staged_metrics        = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[i])
            send_reading(dir_rows[i].rd, dir_rows[i].typed, dir_rows[i].want,
                         $urandom_range(0, 8));
        drain_results();

        // back to back while the result side holds off: fills the pipe
        hold_off_req = 1'b1;
        repeat (PRESSURE_BEATS)
            send_reading(random_reading(), 1'b0, '0, 0);

        // random readings, with no-gap stretches and a full drain midway
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
                drain_results();
            gap = (i % 100 < 25) ? 0 : $urandom_range(0, 8);
            send_reading(random_reading(), 1'b0, '0, gap);
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
